>>> design/mpqh_pkg.sv
`default_nettype none

package mpqh_pkg;

  // Character width actually folded (8..16); the character port stays 16 bits.
  localparam int unsigned CHAR_BITS   = 16;
  localparam int unsigned CHAR_PORT_W = 16;
  localparam int unsigned TYPE_W      = 3;

  localparam int unsigned TABLE_WORDS = 32'h500;
  localparam int unsigned TABLE_AW    = $clog2(TABLE_WORDS);
  localparam int unsigned ROW_WORDS   = 32'h100;
  localparam int unsigned ROW_SETS    = TABLE_WORDS / ROW_WORDS;

  localparam int unsigned HASH_W      = 32;

  localparam logic [HASH_W-1:0] SEED_ONE_INIT = 32'h7FED7FED;
  localparam logic [HASH_W-1:0] SEED_TWO_INIT = 32'hEEEEEEEE;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic                 fold;
    logic                 last;
    logic [TABLE_AW-1:0]  idx;
    logic [CHAR_BITS-1:0] ch;
  } mpqh_op_t;

endpackage

`default_nettype wire

>>> design/mpqh_ram.sv
`default_nettype none

module mpqh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> design/mpqh_table.sv
`default_nettype none

module mpqh_table (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             re_i,
  input  wire logic [mpqh_pkg::TABLE_AW-1:0]    raddr_i,
  output logic      [mpqh_pkg::HASH_W-1:0]      rdata_o,
  output logic                                  ready_o
);
  import mpqh_pkg::*;

  localparam int unsigned S_W   = 22;
  localparam int unsigned X_W   = 29;
  localparam int unsigned R_W   = 24;
  localparam int unsigned ROW_W = $clog2(ROW_WORDS);
  localparam int unsigned SET_W = TABLE_AW - ROW_W;

  localparam logic [S_W-1:0] LCG_START = 22'h100001;
  localparam logic [R_W-1:0] MOD_X1    = 24'h2AAAAB;
  localparam logic [R_W-1:0] MOD_X2    = 24'h555556;
  // three times the modulus is 2^23 + 1, so 2^23 folds in as -1
  localparam logic [R_W-1:0] MOD_X3    = 24'h800001;

  typedef enum logic [1:0] {
    FILL_MUL,
    FILL_RED,
    FILL_DONE
  } fill_state_e;

  fill_state_e       state_q, state_d;
  logic [S_W-1:0]    s_q, s_d;
  logic [R_W-1:0]    r_q, r_d;
  logic              half_q, half_d;
  logic [15:0]       hi_q, hi_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [SET_W-1:0]  set_q, set_d;

  logic [X_W-1:0]    x;
  logic [R_W-1:0]    diff;
  logic [R_W-1:0]    red1;
  logic [R_W-1:0]    red2;
  logic              we;

  always_comb begin
    x    = X_W'(s_q) * X_W'(125) + X_W'(3);
    diff = {1'b0, x[22:0]} - R_W'(x[X_W-1:23]);
    if (diff[R_W-1]) begin
      diff = diff + MOD_X3;
    end
    red1 = (r_q >= MOD_X2) ? r_q - MOD_X2 : r_q;
    red2 = (red1 >= MOD_X1) ? red1 - MOD_X1 : red1;
  end

  always_comb begin
    state_d = state_q;
    s_d     = s_q;
    r_d     = r_q;
    half_d  = half_q;
    hi_d    = hi_q;
    row_d   = row_q;
    set_d   = set_q;
    we      = 1'b0;
    case (state_q)
      FILL_MUL: begin
        r_d     = diff;
        state_d = FILL_RED;
      end
      FILL_RED: begin
        s_d     = red2[S_W-1:0];
        state_d = FILL_MUL;
        if (!half_q) begin
          hi_d   = red2[15:0];
          half_d = 1'b1;
        end else begin
          we     = 1'b1;
          half_d = 1'b0;
          if (set_q == SET_W'(ROW_SETS - 1)) begin
            set_d = '0;
            row_d = row_q + ROW_W'(1);
            if (row_q == ROW_W'(ROW_WORDS - 1)) begin
              state_d = FILL_DONE;
            end
          end else begin
            set_d = set_q + SET_W'(1);
          end
        end
      end
      FILL_DONE: ;
      default: state_d = FILL_DONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FILL_MUL;
      s_q     <= LCG_START;
      half_q  <= 1'b0;
      row_q   <= '0;
      set_q   <= '0;
    end else begin
      state_q <= state_d;
      s_q     <= s_d;
      half_q  <= half_d;
      row_q   <= row_d;
      set_q   <= set_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q  <= r_d;
    hi_q <= hi_d;
  end

  assign ready_o = (state_q == FILL_DONE);

  mpqh_ram #(
    .WIDTH (HASH_W),
    .DEPTH (TABLE_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i ({set_q, row_q}),
    .wdata_i ({hi_q, red2[15:0]}),
    .re_i    (re_i),
    .raddr_i (raddr_i),
    .rdata_o (rdata_o)
  );

endmodule

`default_nettype wire

>>> design/mpqh_front.sv
`default_nettype none

module mpqh_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic [mpqh_pkg::CHAR_PORT_W-1:0]    character_i,
  input  wire logic [mpqh_pkg::TYPE_W-1:0]         hash_type_i,
  input  wire logic                                has_char_i,
  input  wire logic                                is_last_i,
  input  wire logic                                table_ready_i,
  input  wire logic                                q_full_i,
  output logic                                     q_push_o,
  output mpqh_pkg::mpqh_op_t                       q_op_o
);
  import mpqh_pkg::*;

  localparam int unsigned SUM_W = ((CHAR_BITS > 11) ? CHAR_BITS : 11) + 1;

  // x mod 5 for a 9-bit value: 16 is 1 mod 5, so the nibbles just add up
  function automatic logic [2:0] mod5(input logic [8:0] v);
    logic [4:0] t;
    t = 5'(v[8]) + 5'(v[7:4]) + 5'(v[3:0]);
    if (t >= 5'd20) t = t - 5'd20;
    if (t >= 5'd10) t = t - 5'd10;
    if (t >= 5'd5)  t = t - 5'd5;
    return t[2:0];
  endfunction

  logic                 ended_q, ended_d;
  logic [CHAR_BITS-1:0] ch;
  logic [SUM_W-1:0]     sum;
  logic [8:0]           upper;
  logic                 accept;

  assign full   = q_full_i || !table_ready_i;
  assign accept = push && !full;
  assign ch     = character_i[CHAR_BITS-1:0];

  always_comb begin
    sum   = (SUM_W'(hash_type_i) << 8) + SUM_W'(ch);
    upper = 9'(sum[SUM_W-1:8]);
  end

  always_comb begin
    q_op_o.fold = has_char_i && !ended_q && (ch != '0);
    q_op_o.last = is_last_i;
    q_op_o.idx  = {mod5(upper), sum[7:0]};
    q_op_o.ch   = ch;
    ended_d     = ended_q;
    if (accept) begin
      if (is_last_i) begin
        ended_d = 1'b0;
      end else if (has_char_i && (ch == '0)) begin
        ended_d = 1'b1;
      end
    end
  end

  assign q_push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ended_q <= 1'b0;
    end else begin
      ended_q <= ended_d;
    end
  end

endmodule

`default_nettype wire

>>> design/mpqh_queue.sv
`default_nettype none

module mpqh_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire mpqh_pkg::mpqh_op_t  data_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output mpqh_pkg::mpqh_op_t       data_o,
  output logic                     valid_o
);
  import mpqh_pkg::*;

  mpqh_op_t   mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> design/mpqh_back.sv
`default_nettype none

module mpqh_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            q_valid_i,
  input  wire mpqh_pkg::mpqh_op_t              q_op_i,
  output logic                                 q_pop_o,
  output logic                                 rd_en_o,
  output logic [mpqh_pkg::TABLE_AW-1:0]        rd_addr_o,
  input  wire logic [mpqh_pkg::HASH_W-1:0]     rd_data_i,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [mpqh_pkg::HASH_W-1:0]          digest_o
);
  import mpqh_pkg::*;

  logic                 b1_valid_q;
  logic                 b1_fold_q;
  logic                 b1_last_q;
  logic [CHAR_BITS-1:0] b1_ch_q;
  logic                 b1_adv;

  logic [HASH_W-1:0]    seed1_q, seed1_d;
  logic [HASH_W-1:0]    seed2_q, seed2_d;
  logic [HASH_W-1:0]    s1_new, s2_new, res;

  logic [HASH_W-1:0]    out_q [2];
  logic                 owr_q, ord_q;
  logic [1:0]           ocnt_q;
  logic                 out_full, out_push, out_pop;

  assign out_full = (ocnt_q == 2'd2);
  assign b1_adv   = b1_valid_q && (!b1_last_q || !out_full);
  assign q_pop_o  = q_valid_i && (!b1_valid_q || b1_adv);
  assign rd_en_o  = q_pop_o;
  assign rd_addr_o = q_op_i.idx;

  always_comb begin
    s1_new = rd_data_i ^ (seed1_q + seed2_q);
    s2_new = HASH_W'(b1_ch_q) + s1_new + seed2_q + (seed2_q << 5) + HASH_W'(3);
    res     = b1_fold_q ? s1_new : seed1_q;
    seed1_d = seed1_q;
    seed2_d = seed2_q;
    if (b1_adv) begin
      if (b1_last_q) begin
        seed1_d = SEED_ONE_INIT;
        seed2_d = SEED_TWO_INIT;
      end else if (b1_fold_q) begin
        seed1_d = s1_new;
        seed2_d = s2_new;
      end
    end
  end

  assign out_push = b1_adv && b1_last_q;
  assign out_pop  = pop && !empty;
  assign empty    = (ocnt_q == 2'd0);
  assign digest_o = out_q[ord_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
      seed1_q    <= SEED_ONE_INIT;
      seed2_q    <= SEED_TWO_INIT;
      owr_q      <= 1'b0;
      ord_q      <= 1'b0;
      ocnt_q     <= 2'd0;
    end else begin
      if (q_pop_o) begin
        b1_valid_q <= 1'b1;
      end else if (b1_adv) begin
        b1_valid_q <= 1'b0;
      end
      seed1_q <= seed1_d;
      seed2_q <= seed2_d;
      if (out_push) owr_q <= ~owr_q;
      if (out_pop)  ord_q <= ~ord_q;
      ocnt_q <= ocnt_q + 2'(out_push) - 2'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      b1_fold_q <= q_op_i.fold;
      b1_last_q <= q_op_i.last;
      b1_ch_q   <= q_op_i.ch;
    end
    if (out_push) begin
      out_q[owr_q] <= res;
    end
  end

endmodule

`default_nettype wire

>>> design/mpq_string_hash.sv
`default_nettype none

// One-way string hash of the MPQ archive kind, one 16-bit character per
// transfer. Push characters with push/full; set is_last_i on the final
// transfer of a string and one 32-bit hash appears on the result side
// (empty/pop), after which both seeds restart for the next string. A
// transfer with has_char_i low folds nothing; a zero character stops folding
// for the rest of the string. Throughput is one transfer per clock while
// nothing stalls: the front classifies the character and computes the
// table index, a two-entry queue decouples it from the back, which reads
// the 1280-word crypt table (one registered RAM read) and folds both seeds
// together. The hash of a string passes the queue, the back's stage register
// and the result buffer on its way to the result ports; the result side
// buffers two hashes so a slow consumer does not stall input straight away.
// After reset the crypt table is generated in place, each LCG step in a
// multiply and a reduce state, two steps per word; full stays high meanwhile.
module mpq_string_hash (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [mpqh_pkg::CHAR_PORT_W-1:0] character_i,
  input  wire logic [mpqh_pkg::TYPE_W-1:0]      hash_type_i,
  input  wire logic                             has_char_i,
  input  wire logic                             is_last_i,
  output logic                                  empty,
  input  wire logic                             pop,
  output logic [mpqh_pkg::HASH_W-1:0]           digest_o
);
  import mpqh_pkg::*;

  // front to queue
  logic                q_push;
  mpqh_op_t            q_in;
  logic                q_full;
  // queue to back
  logic                q_pop;
  logic                q_valid;
  mpqh_op_t            q_out;
  // back to crypt table
  logic                rd_en;
  logic [TABLE_AW-1:0] rd_addr;
  logic [HASH_W-1:0]   rd_data;
  logic                table_ready;

  mpqh_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data),
    .ready_o (table_ready)
  );

  mpqh_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .character_i   (character_i),
    .hash_type_i   (hash_type_i),
    .has_char_i    (has_char_i),
    .is_last_i     (is_last_i),
    .table_ready_i (table_ready),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_op_o        (q_in)
  );

  // short queue between classification and folding
  mpqh_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .valid_o (q_valid)
  );

  mpqh_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_op_i    (q_out),
    .q_pop_o   (q_pop),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .empty     (empty),
    .pop       (pop),
    .digest_o  (digest_o)
  );

endmodule

`default_nettype wire

>>> tb/sv/mpq_string_hash_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for mpq_string_hash. Strings are streamed in one
// character per transfer; a local model of the two-seed fold predicts the hash
// of every string, and each hash popped from the result side is checked
// against the oldest prediction. Both sides idle at random.
module mpq_string_hash_tb;
  import mpqh_pkg::*;

  // Longest quiet stretch of a correct run is the crypt table build after
  // reset plus one long gap; the limit leaves a wide margin.
  localparam int unsigned IDLE_LIMIT   = 20000;
  // Allows for the path to the result ports and a pop gap still running out.
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam logic [31:0] LCG_START    = 32'h00100001;
  localparam logic [31:0] LCG_MOD      = 32'h002AAAAB;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   push;
  logic                   full;
  logic [CHAR_PORT_W-1:0] character_i;
  logic [TYPE_W-1:0]      hash_type_i;
  logic                   has_char_i;
  logic                   is_last_i;
  logic                   empty;
  logic                   pop;
  logic [HASH_W-1:0]      digest_o;

  mpq_string_hash dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .character_i (character_i),
    .hash_type_i (hash_type_i),
    .has_char_i  (has_char_i),
    .is_last_i   (is_last_i),
    .empty       (empty),
    .pop         (pop),
    .digest_o    (digest_o)
  );

  // Local copy of the crypt table and the running fold of the current string.
  logic [HASH_W-1:0] crypt_words [TABLE_WORDS];
  logic [HASH_W-1:0] fold_seed1;
  logic [HASH_W-1:0] fold_seed2;
  logic              fold_stopped;

  logic [HASH_W-1:0] hash_expected [$];
  logic [HASH_W-1:0] hash_want;
  int unsigned       errors;
  // Set for stretches in which neither side idles.
  logic              no_gaps;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 96) return $urandom_range(12, 4);
    return $urandom_range(50, 20);
  endfunction

  // Fold one transfer into the running seeds; a last transfer yields the hash
  // and restarts the seeds for the next string.
  function automatic void hash_fold(input logic [CHAR_PORT_W-1:0] ch,
                                    input logic [TYPE_W-1:0] ht,
                                    input logic hc, input logic last);
    logic [CHAR_BITS-1:0] c;
    logic [TABLE_AW-1:0]  idx;
    c = ch[CHAR_BITS-1:0];
    if (hc && !fold_stopped) begin
      if (c == '0) begin
        // zero character: rest of the string is ignored
        fold_stopped = 1'b1;
      end else begin
        // types above 4 simply wrap round the table
        idx        = TABLE_AW'(((32'(ht) << 8) + 32'(c)) % TABLE_WORDS);
        fold_seed1 = crypt_words[idx] ^ (fold_seed1 + fold_seed2);
        fold_seed2 = 32'(c) + fold_seed1 + fold_seed2 + (fold_seed2 << 5) + 32'd3;
      end
    end
    if (last) begin
      hash_expected.push_back(fold_seed1);
      fold_seed1   = SEED_ONE_INIT;
      fold_seed2   = SEED_TWO_INIT;
      fold_stopped = 1'b0;
    end
  endfunction

  // Watch both handshakes: predict on every input transfer, check on every
  // result transfer. Values read here are those from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && full === 1'b0)
        hash_fold(character_i, hash_type_i, has_char_i, is_last_i);
      if (pop && empty === 1'b0) begin
        if (hash_expected.size() == 0) begin
          $error("digest: no hash expected, got %h", digest_o);
          errors++;
        end else begin
          hash_want = hash_expected.pop_front();
          if (digest_o !== hash_want) begin
            $error("digest: expected %h, got %h", hash_want, digest_o);
            errors++;
          end
        end
      end
    end
  end

  // Result side: pop held high until a transfer, then maybe a gap.
  initial begin : result_drain
    int unsigned g;
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      pop <= 1'b1;
      do @(posedge clk_i); while (empty !== 1'b0);
      g = gap_len();
      if (g > 0) begin
        pop <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  // Ends the run if no transfer happens on either side for too long.
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((push && full === 1'b0) || (pop && empty === 1'b0)) idle = 0;
      else idle++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // One input transfer. push stays high into the next call when no gap is
  // drawn, so it is never lowered and raised in the same step.
  task automatic send_item(input logic [CHAR_PORT_W-1:0] ch, input logic [TYPE_W-1:0] ht,
                           input logic hc, input logic last);
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    push        <= 1'b1;
    character_i <= ch;
    hash_type_i <= ht;
    has_char_i  <= hc;
    is_last_i   <= last;
    do @(posedge clk_i); while (full !== 1'b0);
  endtask

  // Strings with nothing to fold: the hash is the first seed untouched.
  task automatic test_empty_strings();
    send_item(16'h0000, 3'd0, 1'b0, 1'b1);
    send_item(16'hA5C3, 3'd2, 1'b0, 1'b1);
    send_item(16'h0000, 3'd1, 1'b1, 1'b1);
  endtask

  // Extremes of the character field, including the top of the table.
  task automatic test_char_extremes();
    send_item(16'hFFFF, 3'd4, 1'b1, 1'b1);
    send_item(16'h0001, 3'd0, 1'b1, 1'b1);
    send_item(16'h8000, 3'd3, 1'b1, 1'b0);
    send_item(16'h7FFF, 3'd3, 1'b1, 1'b1);
    repeat (3) send_item(16'hFFFF, 3'd1, 1'b1, 1'b0);
    send_item(16'hFFFF, 3'd1, 1'b1, 1'b1);
  endtask

  // Table row sets, and types past the last set that wrap round.
  task automatic test_hash_types();
    send_item(16'h00FF, 3'd0, 1'b1, 1'b1);
    send_item(16'h00FF, 3'd4, 1'b1, 1'b1);
    send_item(16'h00FF, 3'd5, 1'b1, 1'b1);
    send_item(16'hFF00, 3'd7, 1'b1, 1'b1);
  endtask

  // Zero character stops the fold until the last transfer; a transfer
  // without a character folds nothing mid-string.
  task automatic test_terminators();
    send_item(16'h0041, 3'd0, 1'b1, 1'b0);
    send_item(16'h0000, 3'd0, 1'b1, 1'b0);
    send_item(16'h0042, 3'd0, 1'b1, 1'b0);
    send_item(16'h0000, 3'd0, 1'b0, 1'b0);
    send_item(16'h0043, 3'd0, 1'b1, 1'b1);
    send_item(16'h0041, 3'd0, 1'b1, 1'b1);
    send_item(16'h0041, 3'd2, 1'b1, 1'b0);
    send_item(16'h1234, 3'd2, 1'b0, 1'b0);
    send_item(16'h0042, 3'd2, 1'b1, 1'b1);
  endtask

  // Random strings: mostly well-formed text of random length and content,
  // with zero characters, empty transfers and odd types mixed in.
  task automatic test_random_strings();
    int unsigned counted;
    int unsigned len;
    int unsigned r;
    logic [TYPE_W-1:0]      str_type;
    logic [TYPE_W-1:0]      ht;
    logic [CHAR_PORT_W-1:0] ch;
    logic                   hc;
    logic                   last;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      no_gaps  = ($urandom_range(7) == 0);
      r        = $urandom_range(9);
      len      = (r < 6) ? $urandom_range(8, 1) : (r < 8) ? $urandom_range(40, 9)
                                                          : $urandom_range(3, 1);
      str_type = ($urandom_range(9) == 0) ? TYPE_W'($urandom_range(7))
                                          : TYPE_W'($urandom_range(4));
      for (int unsigned i = 0; i < len; i++) begin
        ht   = ($urandom_range(19) == 0) ? TYPE_W'($urandom_range(7)) : str_type;
        last = (i == len - 1);
        hc   = 1'b1;
        r    = $urandom_range(99);
        if (r < 65)      ch = CHAR_PORT_W'($urandom_range(16'hFFFF, 1));
        else if (r < 85) ch = CHAR_PORT_W'($urandom_range(16'h007F, 1));
        else if (r < 90) ch = '0;
        else begin
          ch = CHAR_PORT_W'($urandom_range(16'hFFFF));
          hc = 1'b0;
        end
        counted++;
        send_item(ch, ht, hc, last);
      end
    end
  endtask

  initial begin : run
    logic [31:0] lcg;
    logic [15:0] hi;
    rst_ni      = 1'b0;
    push        = 1'b0;
    character_i = '0;
    hash_type_i = '0;
    has_char_i  = 1'b0;
    is_last_i   = 1'b0;
    no_gaps     = 1'b0;
    errors      = 0;

    // Crypt table: two LCG steps per word, filled row by row across the sets.
    lcg = LCG_START;
    for (int unsigned r = 0; r < ROW_WORDS; r++) begin
      for (int unsigned k = 0; k < ROW_SETS; k++) begin
        lcg = (lcg * 32'd125 + 32'd3) % LCG_MOD;
        hi  = lcg[15:0];
        lcg = (lcg * 32'd125 + 32'd3) % LCG_MOD;
        crypt_words[TABLE_AW'(r + k * ROW_WORDS)] = {hi, lcg[15:0]};
      end
    end
    fold_seed1   = SEED_ONE_INIT;
    fold_seed2   = SEED_TWO_INIT;
    fold_stopped = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_strings();
    test_char_extremes();
    test_hash_types();
    test_terminators();
    test_random_strings();

    push    <= 1'b0;
    no_gaps = 1'b1;
    while (hash_expected.size() != 0) @(posedge clk_i);
    // any stray hash would show up here
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (hash_expected.size() != 0) begin
      $error("digest: expected %h, got nothing", hash_expected[0]);
      errors++;
    end
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
